FILE: rtl/tts_pkg.sv
// Shared types and constants for the tap tempo sync pulse generator.
package tts_pkg;

  localparam int WORD_W     = 32;
  localparam int DIGIT_W    = 4;
  localparam int NUM_DIGITS = WORD_W / DIGIT_W;
  localparam int IDX_W      = $clog2(NUM_DIGITS);

  localparam logic [15:0] PERIOD_RST   = 16'd261;
  localparam logic [3:0]  PULSE_RST    = 4'd5;
  localparam logic [9:0]  DEBOUNCE_RST = 10'd180;
  localparam logic [15:0] TIMEOUT_RST  = 16'd2000;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_EDGE = 1'b1;

  typedef enum logic [1:0] {
    CFG_PULSE    = 2'd0,
    CFG_DEBOUNCE = 2'd1,
    CFG_TIMEOUT  = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PASS,
    S_POST,
    S_DIV,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic             shift;
    logic [IDX_W-1:0] idx;
    logic             is_tick;
    logic             is_tap;
    logic             first_tap;
    logic             phase_clr;
    logic             du_clr;
  } dp_ctrl_t;

  typedef struct packed {
    logic        phase_ge;
    logic        du_lt;
    logic        timed_out;
    logic [15:0] elapsed;
  } dp_flags_t;

endpackage

FILE: rtl/tap_tempo_sync_pulse_generator_unit.sv
// Tap tempo sync pulse generator: item sequencer, state registers and output stage.
// A tick runs the nibble pass, the update and the result load; a first tap runs the
// pass and the result load; a later tap runs the pass, the divider and the result load;
// any other item goes straight to the result load. One item is worked at a time; the
// next is taken the cycle after its result loads into m_tdata (held while stalled).
// rst is synchronous: counters clear, period 261, button armed, registers to defaults.
module tap_tempo_sync_pulse_generator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] button_level, [7:1] zero
  input  logic        s_tuser,   // [0] op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [0] sync_level, [8:1] tap_count, [24:9] beat_period,
                                 // [25] edge_accepted, [31:26] zero
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);
  import tts_pkg::*;

  state_t            state, state_next;
  logic [IDX_W-1:0]  dig_q;
  logic              is_tick_q, is_tap_q, accepted_q;
  logic [3:0]        pulse_left;
  logic              sync_q;
  logic [15:0]       period_q;
  logic [7:0]        taps_q;
  logic              armed_q;
  logic [3:0]        pulse_cfg;
  logic [9:0]        debounce_cfg;
  logic [15:0]       timeout_cfg;

  dp_ctrl_t          ctrl;
  dp_flags_t         flags;
  logic              div_start, div_busy, div_done;
  logic [15:0]       div_quo;

  logic              s_fire, out_load, last_dig;
  logic [3:0]        pl_sel, pl_new;
  logic              sync_new;

  tts_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .period   (period_q),
    .timeout  (timeout_cfg),
    .debounce (debounce_cfg),
    .flags    (flags)
  );

  tts_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (flags.elapsed),
    .divisor  (taps_q),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign s_fire   = s_tvalid && s_tready;
  assign last_dig = (dig_q == IDX_W'(NUM_DIGITS - 1));

  // Sync pulse update after the phase compare of a tick.
  always_comb begin
    pl_sel   = flags.phase_ge ? pulse_cfg : pulse_left;
    sync_new = flags.phase_ge | sync_q;
    pl_new   = pl_sel;
    if (pl_sel == 4'd0) begin
      sync_new = 1'b0;
    end else begin
      pl_new = pl_sel - 4'd1;
    end
  end

  always_comb begin
    state_next     = state;
    s_tready       = (state == S_IDLE);
    out_load       = 1'b0;
    div_start      = 1'b0;
    ctrl.shift     = 1'b0;
    ctrl.idx       = dig_q;
    ctrl.is_tick   = is_tick_q;
    ctrl.is_tap    = is_tap_q;
    ctrl.first_tap = (taps_q == 8'd0);
    ctrl.phase_clr = 1'b0;
    ctrl.du_clr    = 1'b0;
    case (state)
      S_IDLE: begin
        if (s_fire) begin
          if (s_tuser == OP_TICK || (armed_q && s_tdata[0])) begin
            state_next = S_PASS;
          end else begin
            state_next = S_RESULT;
          end
        end
      end
      S_PASS: begin
        ctrl.shift = 1'b1;
        if (last_dig) begin
          if (is_tick_q) begin
            state_next = S_POST;
          end else if (taps_q == 8'd0) begin
            state_next = S_RESULT;
          end else begin
            div_start  = 1'b1;
            state_next = S_DIV;
          end
        end
      end
      S_POST: begin
        ctrl.phase_clr = flags.phase_ge;
        ctrl.du_clr    = flags.du_lt;
        state_next     = S_RESULT;
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dig_q        <= '0;
      is_tick_q    <= 1'b0;
      is_tap_q     <= 1'b0;
      accepted_q   <= 1'b0;
      pulse_left   <= 4'd0;
      sync_q       <= 1'b0;
      period_q     <= PERIOD_RST;
      taps_q       <= 8'd0;
      armed_q      <= 1'b1;
      m_tvalid     <= 1'b0;
      pulse_cfg    <= PULSE_RST;
      debounce_cfg <= DEBOUNCE_RST;
      timeout_cfg  <= TIMEOUT_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_addr))
          CFG_PULSE:    pulse_cfg    <= cfg_wdata[3:0];
          CFG_DEBOUNCE: debounce_cfg <= cfg_wdata[9:0];
          CFG_TIMEOUT:  timeout_cfg  <= cfg_wdata;
          default:      ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (s_fire) begin
            is_tick_q  <= (s_tuser == OP_TICK);
            is_tap_q   <= (s_tuser == OP_EDGE) && armed_q && s_tdata[0];
            accepted_q <= (s_tuser == OP_EDGE) && armed_q;
            if (s_tuser == OP_EDGE) begin
              armed_q <= 1'b0;
            end
          end
        end
        S_PASS: begin
          dig_q <= dig_q + IDX_W'(1);
          if (last_dig && !is_tick_q && taps_q == 8'd0) begin
            taps_q <= 8'd1;
          end
        end
        S_POST: begin
          pulse_left <= pl_new;
          sync_q     <= sync_new;
          if (flags.du_lt) begin
            armed_q <= 1'b1;
          end
          if (flags.timed_out) begin
            taps_q <= 8'd0;
          end
        end
        S_DIV: begin
          if (div_done) begin
            // Half the mean interval between taps.
            period_q <= {1'b0, div_quo[15:1]};
            taps_q   <= taps_q + 8'd1;
          end
        end
        default: ;
      endcase

      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {6'b0, accepted_q, period_q, taps_q, sync_q};
    end
  end

`ifndef SYNTH
  a_div_only_in_div: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> state == S_DIV)
    else $error("divider busy outside the divide state");

  a_digit_idle_zero: assert property (@(posedge clk) disable iff (rst)
    state != S_PASS |-> dig_q == '0)
    else $error("digit counter not aligned outside a pass");

  a_idle_holds_tempo: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE && !s_fire |=> $stable(taps_q) && $stable(period_q))
    else $error("tap count or period changed without an item");

  a_result_waits: assert property (@(posedge clk) disable iff (rst)
    state == S_RESULT && m_tvalid && !m_tready |=> state == S_RESULT)
    else $error("result dropped while output stage was full");
`endif

endmodule

FILE: rtl/tts_divider.sv
// Restoring divider, one quotient bit per cycle (16-bit dividend, 8-bit divisor).
module tts_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] dividend,
  input  logic [7:0]  divisor,
  output logic        busy,
  output logic        done,
  output logic [15:0] quotient
);

  logic [3:0]  cnt;
  logic [7:0]  rem;
  logic [7:0]  dsr;
  logic [15:0] dvd;
  logic [8:0]  rem_sh;
  logic [8:0]  rem_sub;
  logic        q_bit;

  always_comb begin
    rem_sh  = {rem, dvd[15]};
    rem_sub = rem_sh - {1'b0, dsr};
    q_bit   = (rem_sh >= {1'b0, dsr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        dsr  <= divisor;
        dvd  <= dividend;
      end else if (busy) begin
        // The dividend shifts out at the top while quotient bits fill from below.
        rem <= q_bit ? rem_sub[7:0] : rem_sh[7:0];
        dvd <= {dvd[14:0], q_bit};
        cnt <= cnt + 4'd1;
        if (cnt == 4'd15) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = dvd;

endmodule

FILE: rtl/tts_datapath.sv
// Nibble-serial counters, deadlines and comparators of the tempo generator.
module tts_datapath (
  input  logic                clk,
  input  logic                rst,
  input  tts_pkg::dp_ctrl_t   ctrl,
  input  logic [15:0]         period,
  input  logic [15:0]         timeout,
  input  logic [9:0]          debounce,
  output tts_pkg::dp_flags_t  flags
);
  import tts_pkg::*;

  logic [WORD_W-1:0] time_q, phase_q, du_q, last_q, first_q;
  logic              c_time, c_phase, c_sum, c_du, b_el;
  logic              ge_q, lt_q, gt_q;
  logic [15:0]       el_q;

  logic              first, lo;
  logic [15:0]       deb_ext;
  logic [3:0]        per_d, to_d, deb_d;
  logic [3:0]        t_d, p_d, du_d, l_d, f_d;
  logic [4:0]        tsum, psum, ssum, dsum, ediff;
  logic [3:0]        tn, pn;
  logic              ge_in, lt_in, gt_in;
  logic              ge_n, lt_n, gt_n;

  always_comb begin
    first   = (ctrl.idx == '0);
    lo      = !ctrl.idx[IDX_W-1];
    deb_ext = {6'b0, debounce};
    per_d   = lo ? period[{ctrl.idx[1:0], 2'b00} +: 4] : 4'd0;
    to_d    = lo ? timeout[{ctrl.idx[1:0], 2'b00} +: 4] : 4'd0;
    deb_d   = (ctrl.idx < 3'd3) ? deb_ext[{ctrl.idx[1:0], 2'b00} +: 4] : 4'd0;

    t_d  = time_q[3:0];
    p_d  = phase_q[3:0];
    du_d = du_q[3:0];
    l_d  = last_q[3:0];
    f_d  = first_q[3:0];

    // Carries enter as one for the increments and zero for the sums.
    tsum  = {1'b0, t_d} + {4'b0, (first | c_time)};
    psum  = {1'b0, p_d} + {4'b0, (first | c_phase)};
    ssum  = {1'b0, l_d} + {1'b0, to_d} + {4'b0, (!first & c_sum)};
    dsum  = {1'b0, t_d} + {1'b0, deb_d} + {4'b0, (!first & c_du)};
    ediff = {1'b0, t_d} - {1'b0, f_d} - {4'b0, (!first & b_el)};

    tn = ctrl.is_tick ? tsum[3:0] : t_d;
    pn = psum[3:0];

    // Comparisons run from the low digit up; a higher digit overrides.
    ge_in = first | ge_q;
    lt_in = !first & lt_q;
    gt_in = !first & gt_q;
    ge_n  = (pn > per_d) ? 1'b1 : ((pn < per_d) ? 1'b0 : ge_in);
    lt_n  = (tn > du_d) ? 1'b1 : ((tn < du_d) ? 1'b0 : lt_in);
    gt_n  = (tn > ssum[3:0]) ? 1'b1 : ((tn < ssum[3:0]) ? 1'b0 : gt_in);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_q  <= '0;
      phase_q <= '0;
      du_q    <= '0;
      last_q  <= '0;
      first_q <= '0;
      c_time  <= 1'b0;
      c_phase <= 1'b0;
      c_sum   <= 1'b0;
      c_du    <= 1'b0;
      b_el    <= 1'b0;
      ge_q    <= 1'b0;
      lt_q    <= 1'b0;
      gt_q    <= 1'b0;
    end else if (ctrl.shift) begin
      time_q  <= {tn, time_q[WORD_W-1:DIGIT_W]};
      phase_q <= {(ctrl.is_tick ? pn : p_d), phase_q[WORD_W-1:DIGIT_W]};
      du_q    <= {(ctrl.is_tap ? dsum[3:0] : du_d), du_q[WORD_W-1:DIGIT_W]};
      last_q  <= {(ctrl.is_tap ? t_d : l_d), last_q[WORD_W-1:DIGIT_W]};
      first_q <= {((ctrl.is_tap && ctrl.first_tap) ? t_d : f_d),
                  first_q[WORD_W-1:DIGIT_W]};
      c_time  <= tsum[4];
      c_phase <= psum[4];
      c_sum   <= ssum[4];
      c_du    <= dsum[4];
      b_el    <= ediff[4];
      ge_q    <= ge_n;
      lt_q    <= lt_n;
      gt_q    <= gt_n;
    end else begin
      if (ctrl.phase_clr) begin
        phase_q <= '0;
      end
      if (ctrl.du_clr) begin
        du_q <= '0;
      end
    end
  end

  // Only the low four digits of the elapsed time are kept.
  always_ff @(posedge clk) begin
    if (ctrl.shift && lo) begin
      el_q <= {ediff[3:0], el_q[15:4]};
    end
  end

  assign flags.phase_ge  = ge_q;
  assign flags.du_lt     = lt_q;
  assign flags.timed_out = gt_q;
  assign flags.elapsed   = el_q;

endmodule
